// ===== hdl/canidt_pkg.sv =====
// Package for the CAN receive identifier learning table.
// Holds table sizing, transfer structs, the table entry layout and the FSM states.
// No dependencies.
`default_nettype none

package canidt_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned AddrW      = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);
  localparam int unsigned IdxOutW    = 6;
  localparam int unsigned UsedOutW   = 7;

  typedef struct packed {
    logic        mode;
    logic [28:0] frame_id;
    logic [7:0]  frame_type;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic [5:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [5:0]  entry_index;
    logic        matched;
    logic        learned;
    logic        dropped_full;
    logic [28:0] out_id;
    logic [7:0]  out_type;
    logic [3:0]  out_len;
    logic [63:0] out_data;
    logic [31:0] frame_count;
    logic [6:0]  entries_used;
  } out_t;

  typedef struct packed {
    logic [28:0] id;
    logic [7:0]  ftype;
    logic [3:0]  flen;
    logic [63:0] fdata;
    logic [31:0] count;
  } ent_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    ent_t             ent;
  } wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH,
    ST_MISS
  } state_e;

  localparam logic MODE_FRAME = 1'b0;
  localparam logic MODE_READ  = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/can_receive_id_learning_table_top.sv =====
// Top level of the CAN receive identifier learning table: control FSM,
// linear search over the entry RAM, result register. Depends on canidt_pkg, canidt_store.
//
//   port         dir  kind      meaning
//   start/req_i  in   command   transfer taken when start=1 and busy=0
//   busy         out  status    high while an item is in work
//   done_o/res_o out  strobe    one result, valid for exactly one cycle
//
// Readback: one pass through ST_READ, result strobed in the following cycle.
// Frame: IDLE issues the first RAM read, ST_SEARCH compares one entry per RAM read,
// and a miss passes through ST_MISS.
// Reset clears the entry count and the FSM; RAM contents are left as they are.
// The receiver cannot stall; a new command is taken while a result is strobed.
`default_nettype none

module can_receive_id_learning_table_top (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  input  canidt_pkg::in_t     req_i,
  output logic                done_o,
  output canidt_pkg::out_t    res_o
);
  import canidt_pkg::*;

  state_e           state_q, state_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic             done_q, done_d;
  logic             range_q, range_d;
  in_t              req_q;
  out_t             res_q, res_d;

  wr_t              wr;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  ent_t             rd_ent;

  logic             accept;
  logic             hit;
  logic             last;
  logic             room;
  logic [CntW:0]    idx_nxt;

  assign accept  = start && (state_q == ST_IDLE);
  assign busy    = (state_q != ST_IDLE);
  assign hit     = (rd_ent.id == req_q.frame_id);
  assign idx_nxt = (CntW+1)'(idx_q) + 1'b1;
  assign last    = (idx_nxt >= {1'b0, used_q});
  assign room    = (32'(used_q) < TableDepth);
  assign range_d = ({26'b0, req_i.read_index} < 32'(used_q));

  canidt_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_ent_o  (rd_ent)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_i.mode == MODE_READ) begin
            state_d = ST_READ;
          end else if (used_q == '0) begin
            state_d = ST_MISS;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      ST_SEARCH: begin
        if (hit) begin
          state_d = ST_IDLE;
        end else if (last) begin
          state_d = ST_MISS;
        end
      end
      ST_MISS: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr      = '0;
    idx_d   = idx_q;
    used_d  = used_q;
    done_d  = 1'b0;
    res_d   = '0;
    res_d.entries_used = UsedOutW'(used_q);
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          if (req_i.mode == MODE_READ) begin
            rd_en   = range_d;
            rd_addr = AddrW'(req_i.read_index);
          end else begin
            rd_en = (used_q != '0);
          end
        end
      end
      ST_READ: begin
        done_d            = 1'b1;
        res_d.entry_index = req_q.read_index;
        if (range_q) begin
          res_d.out_id      = rd_ent.id;
          res_d.out_type    = rd_ent.ftype;
          res_d.out_len     = rd_ent.flen;
          res_d.out_data    = rd_ent.fdata;
          res_d.frame_count = rd_ent.count;
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          wr.en             = 1'b1;
          wr.addr           = idx_q;
          wr.ent.id         = rd_ent.id;
          wr.ent.ftype      = req_q.frame_type;
          wr.ent.flen       = req_q.frame_len;
          wr.ent.fdata      = req_q.frame_data;
          wr.ent.count      = rd_ent.count + 32'd1;
          done_d            = 1'b1;
          res_d.entry_index = IdxOutW'(idx_q);
          res_d.matched     = 1'b1;
          res_d.out_id      = wr.ent.id;
          res_d.out_type    = wr.ent.ftype;
          res_d.out_len     = wr.ent.flen;
          res_d.out_data    = wr.ent.fdata;
          res_d.frame_count = wr.ent.count;
        end else if (!last) begin
          rd_en   = 1'b1;
          rd_addr = AddrW'(idx_nxt);
          idx_d   = AddrW'(idx_nxt);
        end
      end
      ST_MISS: begin
        done_d = 1'b1;
        if (room) begin
          wr.en              = 1'b1;
          wr.addr            = AddrW'(used_q);
          wr.ent.id          = req_q.frame_id;
          wr.ent.ftype       = req_q.frame_type;
          wr.ent.flen        = req_q.frame_len;
          wr.ent.fdata       = req_q.frame_data;
          wr.ent.count       = 32'd1;
          used_d             = used_q + 1'b1;
          res_d.entry_index  = IdxOutW'(used_q);
          res_d.learned      = 1'b1;
          res_d.out_id       = wr.ent.id;
          res_d.out_type     = wr.ent.ftype;
          res_d.out_len      = wr.ent.flen;
          res_d.out_data     = wr.ent.fdata;
          res_d.frame_count  = wr.ent.count;
          res_d.entries_used = UsedOutW'(used_d);
        end else begin
          res_d.dropped_full = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      used_q  <= '0;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q   <= req_i;
      range_q <= range_d;
    end
    if (done_d) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_no_rd_wr_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(rd_en && wr.en))
    else $error("RAM read and write in the same cycle");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= TableDepth)
    else $error("entry count beyond table depth");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("work finished without a result strobe");

  a_done_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) != ST_IDLE)
    else $error("result strobe without work");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({res_o.matched, res_o.learned, res_o.dropped_full}))
    else $error("more than one outcome flag");

  a_wr_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (state_q == ST_SEARCH || state_q == ST_MISS))
    else $error("table write outside frame handling");

endmodule

`default_nettype wire

// ===== hdl/canidt_store.sv =====
// Table storage: one synchronous RAM of entries, one write and one read port.
// Read data is registered. Depends on canidt_pkg.
`default_nettype none

module canidt_store (
  input  wire                           clk_i,
  input  canidt_pkg::wr_t               wr_i,
  input  wire                           rd_en_i,
  input  wire [canidt_pkg::AddrW-1:0]   rd_addr_i,
  output canidt_pkg::ent_t              rd_ent_o
);
  import canidt_pkg::*;

  ent_t mem_q [TableDepth];
  ent_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.ent;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_ent_o = rd_q;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for can_receive_id_learning_table_top: a directed stimulus table, random frame and
// readback commands in several idle phases, a full table; checked by a built-in model or presets.
// Depends on canidt_pkg and the RTL top level.
`timescale 1ns / 100ps

module tb;
  import canidt_pkg::*;

  localparam int unsigned CyclesMax     = 1_000_000;
  localparam int unsigned ItemsPerPhase = 430;

  typedef struct {
    bit   typed;
    out_t res;
  } preset_t;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t res;
  } row_t;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  logic done;
  in_t  req;
  out_t res;

  // model of the entry table
  logic [28:0] tbl_id   [TableDepth];
  logic [7:0]  tbl_type [TableDepth];
  logic [3:0]  tbl_len  [TableDepth];
  logic [63:0] tbl_data [TableDepth];
  logic [31:0] tbl_cnt  [TableDepth];
  int unsigned tbl_used;

  out_t        lookup_q[$];
  preset_t     preset_q[$];
  row_t        dir_rows[$];
  logic [28:0] known_ids[$];

  int unsigned mismatches;
  int unsigned cycles;
  int unsigned n_learned, n_matched, n_dropped, n_read;

  can_receive_id_learning_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .done_o (done),
    .res_o  (res)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CyclesMax) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles, lookup_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic void load_entry(ref out_t r, input int unsigned i);
    r.out_id      = tbl_id[i];
    r.out_type    = tbl_type[i];
    r.out_len     = tbl_len[i];
    r.out_data    = tbl_data[i];
    r.frame_count = tbl_cnt[i];
  endfunction

  function automatic out_t table_lookup(in_t it);
    out_t r;
    int   hit;
    r   = '0;
    hit = -1;
    if (it.mode == MODE_READ) begin
      r.entry_index = it.read_index;
      if (it.read_index < tbl_used) load_entry(r, it.read_index);
    end else begin
      for (int i = 0; i < tbl_used; i++) begin
        if (hit < 0 && tbl_id[i] == it.frame_id) hit = i;
      end
      if (hit < 0 && tbl_used < TableDepth) begin
        hit         = tbl_used;
        tbl_id[hit] = it.frame_id;
        tbl_cnt[hit] = 32'd0;
        tbl_used++;
        r.learned   = 1'b1;
      end else if (hit >= 0) begin
        r.matched = 1'b1;
      end
      if (hit >= 0) begin
        tbl_type[hit]  = it.frame_type;
        tbl_len[hit]   = it.frame_len;
        tbl_data[hit]  = it.frame_data;
        tbl_cnt[hit]   = tbl_cnt[hit] + 32'd1;
        r.entry_index  = hit[5:0];
        load_entry(r, hit);
      end else begin
        r.dropped_full = 1'b1;
      end
    end
    r.entries_used = tbl_used[6:0];
    return r;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] e, logic [63:0] a);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, e, a);
  endtask

  task automatic check_result(out_t a);
    out_t e;
    if (lookup_q.size() == 0) begin
      note_mismatch("result with no transfer pending", '0, 64'(a.entry_index));
      return;
    end
    e = lookup_q.pop_front();
    if (e.entry_index !== a.entry_index)
      note_mismatch("entry_index", 64'(e.entry_index), 64'(a.entry_index));
    if (e.matched !== a.matched)
      note_mismatch("matched", 64'(e.matched), 64'(a.matched));
    if (e.learned !== a.learned)
      note_mismatch("learned", 64'(e.learned), 64'(a.learned));
    if (e.dropped_full !== a.dropped_full)
      note_mismatch("dropped_full", 64'(e.dropped_full), 64'(a.dropped_full));
    if (e.out_id !== a.out_id)
      note_mismatch("out_id", 64'(e.out_id), 64'(a.out_id));
    if (e.out_type !== a.out_type)
      note_mismatch("out_type", 64'(e.out_type), 64'(a.out_type));
    if (e.out_len !== a.out_len)
      note_mismatch("out_len", 64'(e.out_len), 64'(a.out_len));
    if (e.out_data !== a.out_data)
      note_mismatch("out_data", e.out_data, a.out_data);
    if (e.frame_count !== a.frame_count)
      note_mismatch("frame_count", 64'(e.frame_count), 64'(a.frame_count));
    if (e.entries_used !== a.entries_used)
      note_mismatch("entries_used", 64'(e.entries_used), 64'(a.entries_used));
    if (a.learned) n_learned++;
    if (a.matched) n_matched++;
    if (a.dropped_full) n_dropped++;
    if (!a.learned && !a.matched && !a.dropped_full) n_read++;
  endtask

  always @(posedge clk_i) begin : monitor
    out_t    predicted;
    preset_t p;
    if (rst_ni) begin
      if (done) check_result(res);
      if (start && !busy) begin
        predicted = table_lookup(req);
        p = preset_q.pop_front();
        lookup_q.push_back(p.typed ? p.res : predicted);
      end
    end
  end

  function automatic bit is_known(logic [28:0] id);
    foreach (known_ids[i]) if (known_ids[i] == id) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [28:0] fresh_id();
    logic [28:0] id;
    do id = 29'($urandom); while (is_known(id));
    return id;
  endfunction

  function automatic in_t frame(logic [28:0] id, logic [7:0] t, logic [3:0] l, logic [63:0] d);
    in_t it;
    it            = '0;
    it.mode       = MODE_FRAME;
    it.frame_id   = id;
    it.frame_type = t;
    it.frame_len  = l;
    it.frame_data = d;
    it.read_index = 6'h3f;
    return it;
  endfunction

  function automatic in_t readback(logic [5:0] idx);
    in_t it;
    it            = '1;
    it.mode       = MODE_READ;
    it.read_index = idx;
    return it;
  endfunction

  function automatic out_t entry(logic [5:0] idx, logic m, logic l, logic [28:0] id,
                                 logic [7:0] t, logic [3:0] len, logic [63:0] d,
                                 logic [31:0] cnt, logic [6:0] used);
    out_t r;
    r              = '0;
    r.entry_index  = idx;
    r.matched      = m;
    r.learned      = l;
    r.out_id       = id;
    r.out_type     = t;
    r.out_len      = len;
    r.out_data     = d;
    r.frame_count  = cnt;
    r.entries_used = used;
    return r;
  endfunction

  function automatic void add_row(in_t it, bit typed = 1'b0, out_t r = '0);
    dir_rows.push_back('{item: it, typed: typed, res: r});
  endfunction

  function automatic in_t rand_item();
    in_t         it;
    int unsigned sel;
    it.mode       = MODE_FRAME;
    it.frame_id   = 29'($urandom);
    it.frame_type = 8'($urandom_range(0, 255));
    it.frame_len  = 4'($urandom_range(0, 15));
    it.frame_data = {$urandom, $urandom};
    it.read_index = 6'($urandom_range(0, 63));
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      it.mode       = MODE_READ;
      it.read_index = 6'($urandom_range(0, known_ids.size() - 1));
    end else if (sel < 88) begin
      it.frame_id = known_ids[$urandom_range(0, known_ids.size() - 1)];
    end
    return it;
  endfunction

  task automatic send(in_t it, bit typed = 1'b0, out_t r = '0);
    preset_q.push_back('{typed: typed, res: r});
    if (it.mode == MODE_FRAME && known_ids.size() < TableDepth && !is_known(it.frame_id))
      known_ids.push_back(it.frame_id);
    start <= 1'b1;
    req   <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle_gap(int unsigned pct);
    int unsigned n;
    n = 0;
    if (pct == 0) return;
    while ($urandom_range(0, 99) < pct) n++;
    if ($urandom_range(0, 19) == 0) n += $urandom_range(40, 90);
    if (n == 0) return;
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (lookup_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned pct [4];
    out_t        full_drop;
    rst_ni = 1'b0;
    start  = 1'b0;
    req    = '0;
    pct    = '{0, 56, 9, 0};

    add_row(frame(29'h0, 8'h00, 4'd0, 64'h0), 1'b1,
            entry(6'd0, 1'b0, 1'b1, 29'h0, 8'h00, 4'd0, 64'h0, 32'd1, 7'd1));
    add_row(frame(29'h1fff_ffff, 8'hff, 4'd8, '1), 1'b1,
            entry(6'd1, 1'b0, 1'b1, 29'h1fff_ffff, 8'hff, 4'd8, '1, 32'd1, 7'd2));
    add_row(frame(29'h0, 8'ha5, 4'd15, 64'h0123_4567_89ab_cdef), 1'b1,
            entry(6'd0, 1'b1, 1'b0, 29'h0, 8'ha5, 4'd15, 64'h0123_4567_89ab_cdef,
                  32'd2, 7'd2));
    add_row(readback(6'd1), 1'b1,
            entry(6'd1, 1'b0, 1'b0, 29'h1fff_ffff, 8'hff, 4'd8, '1, 32'd1, 7'd2));
    add_row(readback(6'd0));
    add_row(frame(29'h1fff_ffff, 8'h00, 4'd0, 64'h0));
    add_row(frame(29'h0aaa_aaaa, 8'h5a, 4'd3, 64'hdead_beef_0bad_f00d));
    add_row(frame(29'h1555_5555, 8'h81, 4'd9, 64'h8000_0000_0000_0001));
    add_row(frame(29'h0aaa_aaaa, 8'h3c, 4'd1, 64'h0000_0000_0000_00ff));
    add_row(readback(6'd3));
    add_row(readback(6'd2));
    add_row(frame(29'h1, 8'h01, 4'd7, 64'hff00_ff00_ff00_ff00));
    add_row(frame(29'h1000_0000, 8'h80, 4'd4, 64'h00ff_00ff_00ff_00ff));
    add_row(readback(6'd5));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    drain();

    foreach (pct[ph]) begin
      repeat (ItemsPerPhase) begin
        send(rand_item());
        idle_gap(pct[ph]);
      end
      drain();
    end

    // table full: fill any remaining entries, then unknown ids must be dropped
    while (known_ids.size() < TableDepth)
      send(frame(fresh_id(), 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                 {$urandom, $urandom}));
    full_drop              = '0;
    full_drop.dropped_full = 1'b1;
    full_drop.entries_used = 7'd64;
    send(frame(fresh_id(), 8'hff, 4'd8, '1), 1'b1, full_drop);
    send(frame(fresh_id(), 8'h00, 4'd0, '0), 1'b1, full_drop);
    send(readback(6'd63));
    send(readback(6'd0));
    send(frame(known_ids[63], 8'h42, 4'd2, 64'h1234));
    start <= 1'b0;

    while (lookup_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("Covered %0d learned, %0d matched, %0d dropped on full table, %0d readbacks",
             n_learned, n_matched, n_dropped, n_read);
    $display("Table fill %0d of %0d entries, %0d mismatches, %0d cycles",
             tbl_used, TableDepth, mismatches, cycles);
    if (mismatches == 0 && lookup_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
